FILE: design/addressed_frame_receiver_assert.svh
// Assertion macros shared by the addressed frame receiver modules.
// Used from module bodies; expects a clock named clk and reset rst_n in scope.
`ifndef ADDRESSED_FRAME_RECEIVER_ASSERT_SVH
`define ADDRESSED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property check, sampled on clk, off during reset
`define AFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define AFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFR_ASSERT(lbl, prop, msg)
`define AFR_ASSERT_IMPL(lbl, ante, cons, msg)
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/afr_pkg.sv
// Package for the addressed frame receiver: sizes, codes, item and state types.
// No dependencies.
package afr_pkg;

    // Frame buffer geometry
    localparam int BUF_DEPTH     = 64;
    localparam int ADDR_W        = $clog2(BUF_DEPTH);
    localparam int PAYLOAD_LIMIT = (BUF_DEPTH - 2 > 62) ? 62 : BUF_DEPTH - 2;
    // byte count holds header plus a full payload
    localparam int COUNT_W       = $clog2(PAYLOAD_LIMIT + 2);

    // Field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int NIB_W  = 4;

    localparam logic [BYTE_W-1:0] TERMINATOR    = 8'h2D;
    localparam logic [NIB_W-1:0]  STATION_RESET = 4'h1;
    localparam logic [NIB_W-1:0]  ACCEPT_RESET  = 4'hA;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic REG_STATION = 1'b0;
    localparam logic REG_ACCEPT  = 1'b1;

    // One delivered payload byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } afr_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } afr_state_t;

endpackage

FILE: design/afr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/afr_out_stage.sv
// Two-entry output queue for payload items, with credit back to the reader.
// Depends on afr_pkg and the assertion macro header.
`include "addressed_frame_receiver_assert.svh"

module afr_out_stage
    import afr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  afr_item_t push_item,
    output afr_item_t out_item,
    output logic      out_valid,
    input  logic      out_stall,
    output logic [1:0] credit
);

    afr_item_t  e0_reg, e0_next;
    afr_item_t  e1_reg, e1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = e0_reg;
    // free slots after this cycle's pop
    assign credit    = 2'(2'd2 - count_reg + {1'b0, pop});

    // Shift-register queue update
    always_comb
    begin
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    e0_next = push_item;
                end
                else
                begin
                    e1_next = push_item;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                e0_next    = e1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    e0_next = push_item;
                end
                else
                begin
                    e0_next = e1_reg;
                    e1_next = push_item;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    `AFR_ASSERT(a_count_range, count_reg != 2'd3, "output queue count out of range")
    `AFR_ASSERT_IMPL(a_no_overflow, push && !pop, count_reg != 2'd2, "push into full queue")
    `AFR_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(out_item),
        "stalled item changed")

endmodule

FILE: design/addressed_frame_receiver.sv
// Addressed frame receiver top level: header match, payload store, replay.
// Depends on afr_pkg, afr_ram, afr_out_stage and the assertion macro header.
//
//   Channel   Signals                                      Direction
//   rx        rx_valid, rx_stall, rx_byte                  in  (stall driven here)
//   payload   payload_valid, payload_stall, payload_byte,  out (stall driven by sink)
//             payload_position, last_flag
//   config    psel, penable, pwrite, paddr, pwdata,        APB slave, pready tied high
//             prdata, pready
//
// A byte that does not end an accepted frame is taken without a stall; rx_stall
// stays low. A terminator of an accepted frame with N payload bytes stalls rx
// while the frame store is read back one entry a cycle through its single read
// port; payload stalls stretch this. Reset clears control state only; the frame
// store needs no clearing, as only entries written in the current frame are read.
`include "addressed_frame_receiver_assert.svh"

module addressed_frame_receiver
    import afr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // received bytes
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    // payload items
    output logic               payload_valid,
    input  logic               payload_stall,
    output logic [BYTE_W-1:0]  payload_byte,
    output logic [POS_W-1:0]   payload_position,
    output logic               last_flag,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    afr_state_t state_reg, state_next;

    logic [NIB_W-1:0]   station_reg;
    logic [NIB_W-1:0]   accept_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [NIB_W-1:0]   type_reg, type_next;
    logic [POS_W-1:0]   plen_reg, plen_next;
    logic [POS_W-1:0]   k_reg, k_next;
    logic               rd_pending_reg;
    logic [POS_W-1:0]   rd_pos_reg;
    logic               rd_last_reg;

    logic               rx_accept;
    logic               is_header;
    logic               is_term;
    logic               addr_match;
    logic               overfull;
    logic               start_replay;
    logic               ram_we;
    logic               issue;
    logic               last_issue;
    logic               cfg_write;
    logic               reg_sel;
    logic [ADDR_W-1:0]  raddr;
    logic [BYTE_W-1:0]  rdata;
    logic [1:0]         credit;
    afr_item_t          push_item;
    afr_item_t          out_item;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[REG_IDX_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= STATION_RESET;
            accept_reg  <= ACCEPT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_STATION: station_reg <= pwdata[NIB_W-1:0];
                REG_ACCEPT:  accept_reg  <= pwdata[NIB_W-1:0];
                default:     station_reg <= station_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_STATION: prdata = PDATA_W'(station_reg);
            REG_ACCEPT:  prdata = PDATA_W'(accept_reg);
            default:     prdata = '0;
        endcase
    end

    // Byte classification
    assign rx_accept  = rx_valid && !rx_stall;
    assign is_header  = (count_reg == '0);
    assign is_term    = (rx_byte == TERMINATOR);
    assign addr_match = (rx_byte[BYTE_W-1:NIB_W] == station_reg);
    assign overfull   = (COUNT_W'(count_reg - COUNT_W'(1)) >= COUNT_W'(PAYLOAD_LIMIT));

    assign start_replay = rx_accept && !is_header && is_term
                          && (type_reg == accept_reg) && (count_reg != COUNT_W'(1));
    assign ram_we       = rx_accept && !is_header && !is_term && !overfull;

    // Frame bookkeeping
    always_comb
    begin
        count_next = count_reg;
        type_next  = type_reg;
        plen_next  = plen_reg;
        if (rx_accept)
        begin
            if (is_header)
            begin
                if (addr_match)
                begin
                    count_next = COUNT_W'(1);
                    type_next  = rx_byte[NIB_W-1:0];
                end
            end
            else if (is_term)
            begin
                count_next = '0;
                plen_next  = POS_W'(count_reg - COUNT_W'(1));
            end
            else if (overfull)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // Replay read issue: only when the output queue will have room for it
    assign last_issue = (k_reg == POS_W'(plen_reg - POS_W'(1)));
    assign raddr      = ADDR_W'(k_reg) + ADDR_W'(1);

    always_comb
    begin
        k_next = k_reg;
        if (start_replay)
        begin
            k_next = '0;
        end
        else if (issue)
        begin
            k_next = k_reg + POS_W'(1);
        end
    end

    // State machine: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_replay)
                begin
                    state_next = ST_REPLAY;
                end
            end
            ST_REPLAY:
            begin
                if (issue && last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine: outputs
    always_comb
    begin
        rx_stall = 1'b1;
        issue    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rx_stall = 1'b0;
            end
            ST_REPLAY:
            begin
                issue = (credit > {1'b0, rd_pending_reg});
            end
            default:
            begin
                rx_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            type_reg       <= '0;
            plen_reg       <= '0;
            k_reg          <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            type_reg       <= type_next;
            plen_reg       <= plen_next;
            k_reg          <= k_next;
            rd_pending_reg <= issue;
        end
    end

    // Position and last mark travel with the read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_pos_reg  <= k_reg;
            rd_last_reg <= last_issue;
        end
    end

    // Frame store; writes and replay reads never overlap since rx is stalled
    afr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(count_reg)),
        .wdata (rx_byte),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign push_item.data = rdata;
    assign push_item.pos  = rd_pos_reg;
    assign push_item.last = rd_last_reg;

    afr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_pending_reg),
        .push_item (push_item),
        .out_item  (out_item),
        .out_valid (payload_valid),
        .out_stall (payload_stall),
        .credit    (credit)
    );

    assign payload_byte     = out_item.data;
    assign payload_position = out_item.pos;
    assign last_flag        = out_item.last;

    `AFR_ASSERT_IMPL(a_no_write_in_replay, ram_we, state_reg == ST_IDLE,
        "frame store written during replay")
    `AFR_ASSERT(a_count_bound, count_reg <= COUNT_W'(PAYLOAD_LIMIT + 1),
        "byte count beyond payload limit")
    `AFR_ASSERT_NEXT(a_last_ends_replay, issue && last_issue, state_reg == ST_IDLE,
        "replay continued past final payload byte")

endmodule
